[sv/cbt_pkg.sv]
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants for the counted bit table with max pop.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // Default table geometry
    localparam int ENTRIES_DEF    = 64;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths of the stream items
    localparam int CMD_W   = 4;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 16;
    localparam int SMALL_W = 7;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 40;

    // Command codes; unassigned codes behave as query
    typedef enum logic [CMD_W-1:0] {
        CMD_SET       = 4'd0,
        CMD_RESET     = 4'd1,
        CMD_DEC       = 4'd2,
        CMD_FLIP      = 4'd3,
        CMD_SET_ALL   = 4'd4,
        CMD_RESET_ALL = 4'd5,
        CMD_DEC_ALL   = 4'd6,
        CMD_FLIP_ALL  = 4'd7,
        CMD_POP       = 4'd8,
        CMD_QUERY     = 4'd9
    } cmd_t;

    // Per-entry update applied during the modify sweep
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET,
        OP_RESET,
        OP_DEC,
        OP_FLIP
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_MOD,
        ST_DONE
    } state_t;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic               error;
        logic               any_set;
        logic [SMALL_W-1:0] first_set_index;
        logic [SMALL_W-1:0] set_bits_total;
        logic [SMALL_W-1:0] popped_index;
        logic [CNT_W-1:0]   count_at_index;
        logic               bit_at_index;
    } result_t;

endpackage

[sv/counted_bit_table_max_pop.sv]
// ----------------------------------------------------------------------------
// counted_bit_table_max_pop
// Table of presence bits and saturating hit counts with whole-table commands
// and a pop of the largest count.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | command: cmd, index
//  m_axis   | out       | result: bit, count, popped, total, first, any, error
//
//  Each command runs one modify sweep through the table memory (one read
//  port, one write port), then a result state and an idle state; s_axis
//  takes no new command until the sequencer is back in idle. Pop adds a
//  search sweep for the largest count before the modify sweep.
//  After reset a clearing pass zeroes every entry before s_axis_tready.
//  A result held in the output register lets the next command start; the
//  sequencer waits at its end only while that register is full and undrained.
// ----------------------------------------------------------------------------
module counted_bit_table_max_pop #(
    parameter int ENTRIES    = cbt_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = cbt_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [3:0] cmd, [9:4] index, [15:10] zero
    input  logic [cbt_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] bit_at_index, [16:1] count_at_index, [23:17] popped_index,
    // [30:24] set_bits_total, [37:31] first_set_index, [38] any_set, [39] error
    output logic [cbt_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int IW = $clog2(ENTRIES);

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [COUNT_BITS:0]  rd_data;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [COUNT_BITS:0]  wr_data;
    logic                 res_valid;
    logic                 res_ready;
    cbt_pkg::result_t     res;
    logic                 out_valid_reg;
    cbt_pkg::result_t     out_data_reg;

    cbt_store #(
        .ENTRIES (ENTRIES),
        .WIDTH   (COUNT_BITS + 1)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    cbt_ctrl #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (s_axis_tdata[3:0]),
        .index     (s_axis_tdata[9:4]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Load the output register when it is empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[sv/cbt_store.sv]
// ----------------------------------------------------------------------------
// cbt_store
// Table memory: one synchronous read port, one write port, registered read.
// ----------------------------------------------------------------------------
module cbt_store #(
    parameter int ENTRIES = cbt_pkg::ENTRIES_DEF,
    parameter int WIDTH   = cbt_pkg::COUNT_BITS_DEF + 1
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic [WIDTH-1:0]           rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  logic [WIDTH-1:0]           wr_data
);

    logic [WIDTH-1:0] mem [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/cbt_ctrl.sv]
// ----------------------------------------------------------------------------
// cbt_ctrl
// Sweep sequencer: clears the table after reset, finds the pop target and
// runs a read-modify-write pass over every entry while it gathers the summary.
// ----------------------------------------------------------------------------
module cbt_ctrl #(
    parameter int ENTRIES    = cbt_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = cbt_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [cbt_pkg::CMD_W-1:0]     cmd,
    input  logic [cbt_pkg::IDX_W-1:0]     index,
    // table memory
    output logic                          rd_en,
    output logic [$clog2(ENTRIES)-1:0]    rd_addr,
    input  logic [COUNT_BITS:0]           rd_data,
    output logic                          wr_en,
    output logic [$clog2(ENTRIES)-1:0]    wr_addr,
    output logic [COUNT_BITS:0]           wr_data,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output cbt_pkg::result_t              res
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    cbt_pkg::state_t state_reg, state_next;

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      pv_reg;
    logic [IW-1:0]             pa_reg;
    cbt_pkg::cmd_t             cmd_reg;
    logic [cbt_pkg::IDX_W-1:0] idx_reg;
    logic [COUNT_BITS-1:0]     best_cnt_reg, best_cnt_next;
    logic [IW-1:0]             best_idx_reg, best_idx_next;
    logic [CW-1:0]             total_reg, total_next;
    logic [CW-1:0]             first_reg, first_next;
    logic                      rep_bit_reg, rep_bit_next;
    logic [COUNT_BITS-1:0]     rep_cnt_reg, rep_cnt_next;

    logic                  sweep_last;
    logic                  in_range;
    logic                  is_whole;
    logic                  is_single;
    logic                  is_pop;
    logic                  pop_hit;
    logic                  rep_valid;
    logic [IW-1:0]         rep_addr;
    logic                  rd_bit;
    logic [COUNT_BITS-1:0] rd_cnt;
    cbt_pkg::op_t          base_op;
    cbt_pkg::op_t          op;
    logic                  new_bit;
    logic [COUNT_BITS-1:0] new_cnt;

    // Decode the held command
    always_comb
    begin
        in_range  = 32'(idx_reg) < ENTRIES;
        is_whole  = 1'b0;
        is_single = 1'b0;
        is_pop    = 1'b0;
        base_op   = cbt_pkg::OP_NONE;
        case (cmd_reg)
            cbt_pkg::CMD_SET:       begin is_single = 1'b1; base_op = cbt_pkg::OP_SET;   end
            cbt_pkg::CMD_RESET:     begin is_single = 1'b1; base_op = cbt_pkg::OP_RESET; end
            cbt_pkg::CMD_DEC:       begin is_single = 1'b1; base_op = cbt_pkg::OP_DEC;   end
            cbt_pkg::CMD_FLIP:      begin is_single = 1'b1; base_op = cbt_pkg::OP_FLIP;  end
            cbt_pkg::CMD_SET_ALL:   begin is_whole  = 1'b1; base_op = cbt_pkg::OP_SET;   end
            cbt_pkg::CMD_RESET_ALL: begin is_whole  = 1'b1; base_op = cbt_pkg::OP_RESET; end
            cbt_pkg::CMD_DEC_ALL:   begin is_whole  = 1'b1; base_op = cbt_pkg::OP_DEC;   end
            cbt_pkg::CMD_FLIP_ALL:  begin is_whole  = 1'b1; base_op = cbt_pkg::OP_FLIP;  end
            cbt_pkg::CMD_POP:       begin is_pop    = 1'b1; base_op = cbt_pkg::OP_DEC;   end
            default:                begin base_op = cbt_pkg::OP_NONE; end
        endcase
        pop_hit   = best_cnt_reg != '0;
        rep_valid = is_pop ? pop_hit : in_range;
        rep_addr  = is_pop ? best_idx_reg : IW'(idx_reg);
    end

    // Split the read word and pick the update for the entry coming back
    always_comb
    begin
        rd_bit     = rd_data[COUNT_BITS];
        rd_cnt     = rd_data[COUNT_BITS-1:0];
        sweep_last = pv_reg && (pa_reg == IW'(ENTRIES - 1));
        op         = cbt_pkg::OP_NONE;
        if (is_whole)
        begin
            op = base_op;
        end
        else if (is_single && in_range && (32'(pa_reg) == 32'(idx_reg)))
        begin
            op = base_op;
        end
        else if (is_pop && pop_hit && (pa_reg == best_idx_reg))
        begin
            op = base_op;
        end
    end

    // Entry update rules
    always_comb
    begin
        new_bit = rd_bit;
        new_cnt = rd_cnt;
        case (op)
            cbt_pkg::OP_SET:
            begin
                new_bit = 1'b1;
                new_cnt = (rd_cnt == CMAX) ? rd_cnt : rd_cnt + 1'b1;
            end
            cbt_pkg::OP_RESET:
            begin
                new_bit = 1'b0;
                new_cnt = '0;
            end
            cbt_pkg::OP_DEC:
            begin
                if (rd_cnt != '0)
                begin
                    new_cnt = rd_cnt - 1'b1;
                    new_bit = (rd_cnt == COUNT_BITS'(1)) ? 1'b0 : rd_bit;
                end
            end
            cbt_pkg::OP_FLIP:
            begin
                new_bit = ~rd_bit;
            end
            default:
            begin
                new_bit = rd_bit;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbt_pkg::ST_CLEAR:
                if (cnt_reg[IW-1:0] == IW'(ENTRIES - 1))
                    state_next = cbt_pkg::ST_IDLE;
            cbt_pkg::ST_IDLE:
                if (cmd_valid)
                    state_next = (cmd == cbt_pkg::CMD_POP) ? cbt_pkg::ST_FIND
                                                           : cbt_pkg::ST_MOD;
            cbt_pkg::ST_FIND:
                if (sweep_last)
                    state_next = cbt_pkg::ST_MOD;
            cbt_pkg::ST_MOD:
                if (sweep_last)
                    state_next = cbt_pkg::ST_DONE;
            cbt_pkg::ST_DONE:
                if (res_ready)
                    state_next = cbt_pkg::ST_IDLE;
            default:
                state_next = cbt_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd_ready = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = pa_reg;
        wr_data   = {new_bit, new_cnt};
        rd_addr   = cnt_reg[IW-1:0];
        case (state_reg)
            cbt_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[IW-1:0];
                wr_data = '0;
            end
            cbt_pkg::ST_IDLE:
                cmd_ready = 1'b1;
            cbt_pkg::ST_FIND:
                rd_en = cnt_reg < CW'(ENTRIES);
            cbt_pkg::ST_MOD:
            begin
                rd_en = cnt_reg < CW'(ENTRIES);
                wr_en = pv_reg && (op != cbt_pkg::OP_NONE);
            end
            cbt_pkg::ST_DONE:
                res_valid = 1'b1;
            default:
                cmd_ready = 1'b0;
        endcase
    end

    // Sweep counter and accumulators
    always_comb
    begin
        cnt_next      = cnt_reg;
        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        total_next    = total_reg;
        first_next    = first_reg;
        rep_bit_next  = rep_bit_reg;
        rep_cnt_next  = rep_cnt_reg;
        case (state_reg)
            cbt_pkg::ST_CLEAR:
                cnt_next = cnt_reg + 1'b1;
            cbt_pkg::ST_IDLE:
            begin
                cnt_next      = '0;
                best_cnt_next = '0;
                best_idx_next = '0;
                total_next    = '0;
                first_next    = CW'(ENTRIES);
                rep_bit_next  = 1'b0;
                rep_cnt_next  = '0;
            end
            cbt_pkg::ST_FIND:
            begin
                if (rd_en)
                    cnt_next = cnt_reg + 1'b1;
                if (pv_reg && (rd_cnt > best_cnt_reg))
                begin
                    best_cnt_next = rd_cnt;
                    best_idx_next = pa_reg;
                end
                if (sweep_last)
                    cnt_next = '0;
            end
            cbt_pkg::ST_MOD:
            begin
                if (rd_en)
                    cnt_next = cnt_reg + 1'b1;
                if (pv_reg)
                begin
                    total_next = total_reg + CW'(new_bit);
                    if (new_bit && (first_reg == CW'(ENTRIES)))
                        first_next = CW'(pa_reg);
                    if (rep_valid && (pa_reg == rep_addr))
                    begin
                        rep_bit_next = new_bit;
                        rep_cnt_next = new_cnt;
                    end
                end
            end
            default:
                cnt_next = cnt_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbt_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= rd_en;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pa_reg       <= cnt_reg[IW-1:0];
        best_cnt_reg <= best_cnt_next;
        best_idx_reg <= best_idx_next;
        total_reg    <= total_next;
        first_reg    <= first_next;
        rep_bit_reg  <= rep_bit_next;
        rep_cnt_reg  <= rep_cnt_next;
        if (cmd_ready && cmd_valid)
        begin
            cmd_reg <= cbt_pkg::cmd_t'(cmd);
            idx_reg <= index;
        end
    end

    // Assemble the result
    always_comb
    begin
        res.bit_at_index    = rep_bit_reg;
        res.count_at_index  = cbt_pkg::CNT_W'(rep_cnt_reg);
        res.popped_index    = (is_pop && pop_hit) ? cbt_pkg::SMALL_W'(best_idx_reg)
                                                  : cbt_pkg::SMALL_W'(ENTRIES);
        res.set_bits_total  = cbt_pkg::SMALL_W'(total_reg);
        res.first_set_index = cbt_pkg::SMALL_W'(first_reg);
        res.any_set         = total_reg != '0;
        res.error           = !is_whole && !is_pop && !in_range;
    end

endmodule
